// ----- hw/rtl/bfbp_pkg.sv -----
// bfbp_pkg: shared types and field widths for the best-fit buffer pool.
// No dependencies; imported by best_fit_buffer_pool.
package bfbp_pkg;

    localparam int unsigned SLOTS_DEF  = 16;
    localparam int unsigned BYTES_W    = 24;   // request / capacity / used sizes
    localparam int unsigned ID_W       = 16;
    localparam int unsigned ALLOC_W    = 25;
    localparam int unsigned FREE_W     = 7;
    localparam int unsigned QCNT_W     = 16;
    localparam int unsigned QBYTES_W   = 32;
    localparam int unsigned S_TDATA_W  = 88;
    localparam int unsigned M_TDATA_W  = 112;
    localparam int unsigned M_TUSER_W  = 2;

    typedef enum logic {
        CMD_GET     = 1'b0,
        CMD_RECYCLE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

endpackage

// ----- hw/rtl/best_fit_buffer_pool.sv -----
// best_fit_buffer_pool: best-fit free-buffer pool with a one-slot-per-cycle scan.
// Depends on bfbp_pkg (widths, command codes, sequencer states).
//
// Usage:
//   Slave channel (i_s_*) takes one command word: a get (tuser = 0) asks for a
//   buffer of req_bytes; a recycle (tuser = 1) returns buffer buf_id.
//   Master channel (o_m_*) gives exactly one result word per command: hit or
//   miss with the reused id or the size to allocate, the dropped buffer on a
//   full-pool recycle, and the free / queued counters after the command.
// Timing:
//   After a word is accepted the sequencer reads the slot memory one entry per
//   cycle, a drain state compares the last entry, and a commit state updates the
//   pool and loads the output register, waiting until that register is free.
//   The scan is serial because of the single read port of the slot memory and
//   the shared comparator; a new command is taken only after the commit.
//   o_s_tready is high only while the sequencer is idle.
// Stall:
//   The result waits in the output register; the next command can be taken and
//   scanned meanwhile, and only its commit waits for the register to empty.
// Reset:
//   Synchronous, active low. Empties the pool (valid bits), zeroes the counters
//   and drops any pending result. Slot ids and capacities need no clearing.
module best_fit_buffer_pool
    import bfbp_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF   // 1 .. 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [23:0] req_bytes, [39:24] buf_id, [63:40] buf_capacity, [87:64] buf_used_bytes
    input  logic [S_TDATA_W-1:0]   i_s_tdata,
    // [0] cmd
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [15:0] out_id, [40:16] alloc_bytes, [56:41] dropped_id, [63:57] free_count,
    // [79:64] queued_count, [111:80] queued_bytes
    output logic [M_TDATA_W-1:0]   o_m_tdata,
    // [0] hit, [1] dropped
    output logic [M_TUSER_W-1:0]   o_m_tuser
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    // Slot memory: id and capacity, one write and one registered read port.
    logic [ID_W-1:0]    r_mem_id  [SLOTS];
    logic [BYTES_W-1:0] r_mem_cap [SLOTS];
    logic [SLOTS-1:0]   r_valid;

    t_state r_state, n_state;

    // Captured command
    t_cmd               r_cmd;
    logic [BYTES_W-1:0] r_req;
    logic [ID_W-1:0]    r_bid;
    logic [BYTES_W-1:0] r_bcap;
    logic [BYTES_W-1:0] r_bused;

    // Scan address and read stage
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_go;
    logic [ID_W-1:0]    r_rd_id;
    logic [BYTES_W-1:0] r_rd_cap;

    // Scan results
    logic               r_best_found;
    logic [IW-1:0]      r_best_idx;
    logic [BYTES_W-1:0] r_best_cap;
    logic [ID_W-1:0]    r_best_id;
    logic               r_empty_found;
    logic [IW-1:0]      r_empty_idx;

    // Pool counters
    logic [FREE_W-1:0]   r_free;
    logic [QCNT_W-1:0]   r_qcnt;
    logic [QBYTES_W-1:0] r_qbytes;

    // Output register
    logic                r_m_valid;
    logic                r_o_hit;
    logic [ID_W-1:0]     r_o_id;
    logic [ALLOC_W-1:0]  r_o_alloc;
    logic                r_o_drop;
    logic [ID_W-1:0]     r_o_did;

    logic s_acc;
    logic out_free;
    logic do_commit;
    logic rd_en;
    logic slot_v;
    logic fits;
    logic better;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign out_free  = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        do_commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    do_commit = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared comparator: one slot per cycle
    assign slot_v = r_valid[r_rd_idx];
    assign fits   = (r_cmd == CMD_RECYCLE) || (r_rd_cap >= r_req);
    assign better = !r_best_found || (r_rd_cap < r_best_cap);

    // Memory read port and scan address
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_id  <= r_mem_id[r_idx];
            r_rd_cap <= r_mem_cap[r_idx];
        end
        r_rd_idx <= r_idx;
        if (s_acc) begin
            r_idx <= '0;
        end else if (rd_en && r_idx != LAST_IDX) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_go <= 1'b0;
        end else begin
            r_rd_go <= rd_en;
        end
    end

    // Command capture and scan trackers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cmd         <= t_cmd'(i_s_tuser);
            r_req         <= i_s_tdata[23:0];
            r_bid         <= i_s_tdata[39:24];
            r_bcap        <= i_s_tdata[63:40];
            r_bused       <= i_s_tdata[87:64];
            r_best_found  <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (r_rd_go) begin
            if (slot_v && fits && better) begin
                r_best_found <= 1'b1;
                r_best_idx   <= r_rd_idx;
                r_best_cap   <= r_rd_cap;
                r_best_id    <= r_rd_id;
            end
            if (!slot_v && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_rd_idx;
            end
        end
    end

    // Commit: memory write and result payload
    always_ff @(posedge i_clk) begin
        if (do_commit) begin
            r_o_hit   <= 1'b0;
            r_o_id    <= '0;
            r_o_alloc <= '0;
            r_o_drop  <= 1'b0;
            r_o_did   <= '0;
            if (r_cmd == CMD_GET) begin
                if (r_best_found) begin
                    r_o_hit <= 1'b1;
                    r_o_id  <= r_best_id;
                end else begin
                    r_o_alloc <= {r_req, 1'b0};
                end
            end else if (r_empty_found) begin
                r_mem_id[r_empty_idx]  <= r_bid;
                r_mem_cap[r_empty_idx] <= r_bcap;
            end else if (r_best_found) begin
                r_o_drop <= 1'b1;
                if (r_bcap > r_best_cap) begin
                    r_o_did               <= r_best_id;
                    r_mem_id[r_best_idx]  <= r_bid;
                    r_mem_cap[r_best_idx] <= r_bcap;
                end else begin
                    r_o_did <= r_bid;
                end
            end
        end
    end

    // Control state: valid bits, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_free    <= '0;
            r_qcnt    <= '0;
            r_qbytes  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (do_commit) begin
                r_m_valid <= 1'b1;
                if (r_cmd == CMD_GET) begin
                    r_qcnt   <= r_qcnt + 1'b1;
                    r_qbytes <= r_qbytes + QBYTES_W'(r_req);
                    if (r_best_found) begin
                        r_valid[r_best_idx] <= 1'b0;
                        r_free              <= r_free - 1'b1;
                    end
                end else begin
                    r_qcnt   <= r_qcnt - 1'b1;
                    r_qbytes <= r_qbytes - QBYTES_W'(r_bused);
                    if (r_empty_found) begin
                        r_valid[r_empty_idx] <= 1'b1;
                        r_free               <= r_free + 1'b1;
                    end
                end
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = {r_o_drop, r_o_hit};
    assign o_m_tdata  = {r_qbytes, r_qcnt, r_free, r_o_did, r_o_alloc, r_o_id};

endmodule

// ----- test/best_fit_buffer_pool_tb.sv -----
// best_fit_buffer_pool_tb: self-checking bench for the best-fit buffer pool.
// Drives command words on the slave stream and checks every result word against a pool
// model kept here. Depends on bfbp_pkg and best_fit_buffer_pool.
module best_fit_buffer_pool_tb;
    import bfbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POOL_SLOTS   = SLOTS_DEF;
    localparam int unsigned RANDOM_WORDS = 1325;
    localparam int unsigned SINK_HOLD_AT = 450;   // words taken before the long sink stall
    localparam int unsigned SINK_HOLD    = 400;   // cycles the sink stays off
    localparam int unsigned QUIET_TAIL   = 150;   // last words run with no idling
    localparam int unsigned WATCHDOG     = 4000;  // cycles without any handshake

    // one command word as the sender sees it
    typedef struct packed {
        t_cmd              op;
        logic [BYTES_W-1:0] req;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] cap;
        logic [BYTES_W-1:0] used;
        logic               drain_first;   // sender waits for all results before offering it
    } pool_cmd_t;

    // one result word, fields as the block reports them
    typedef struct packed {
        logic                hit;
        logic [ID_W-1:0]     out_id;
        logic [ALLOC_W-1:0]  alloc;
        logic                dropped;
        logic [ID_W-1:0]     dropped_id;
        logic [FREE_W-1:0]   free_cnt;
        logic [QCNT_W-1:0]   q_cnt;
        logic [QBYTES_W-1:0] q_bytes;
    } pool_res_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 i_s_tuser  = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;

    best_fit_buffer_pool #(
        .SLOTS(POOL_SLOTS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------------------------------
    // Pool model: slot table plus the three counters, updated once per accepted word.
    // ---------------------------------------------------------------------------------------
    logic                pool_live [POOL_SLOTS];
    logic [ID_W-1:0]     pool_id   [POOL_SLOTS];
    logic [BYTES_W-1:0]  pool_cap  [POOL_SLOTS];
    logic [FREE_W-1:0]   live_cnt  = '0;
    logic [QCNT_W-1:0]   out_cnt   = '0;
    logic [QBYTES_W-1:0] byte_sum  = '0;

    initial begin
        for (int k = 0; k < POOL_SLOTS; k++) begin
            pool_live[k] = 1'b0;
            pool_id[k]   = '0;
            pool_cap[k]  = '0;
        end
    end

    function automatic pool_res_t pool_step(pool_cmd_t c);
        pool_res_t r;
        int        best;
        int        empty;
        r     = '0;
        best  = -1;
        empty = -1;
        if (c.op == CMD_GET) begin
            // smallest capacity that still fits; strict compare keeps the lowest index on ties
            for (int k = 0; k < POOL_SLOTS; k++) begin
                if (pool_live[k] && pool_cap[k] >= c.req &&
                    (best < 0 || pool_cap[k] < pool_cap[best]))
                    best = k;
            end
            if (best >= 0) begin
                r.hit           = 1'b1;
                r.out_id        = pool_id[best];
                pool_live[best] = 1'b0;
                live_cnt        = live_cnt - 1'b1;
            end else begin
                r.alloc = {c.req, 1'b0};
            end
            out_cnt  = out_cnt + 1'b1;
            byte_sum = byte_sum + QBYTES_W'(c.req);
        end else begin
            out_cnt  = out_cnt - 1'b1;
            byte_sum = byte_sum - QBYTES_W'(c.used);
            // first hole wins; the smallest slot only matters when there is no hole
            for (int k = 0; k < POOL_SLOTS; k++) begin
                if (empty < 0) begin
                    if (!pool_live[k])
                        empty = k;
                    else if (best < 0 || pool_cap[k] < pool_cap[best])
                        best = k;
                end
            end
            if (empty >= 0) begin
                pool_live[empty] = 1'b1;
                pool_id[empty]   = c.id;
                pool_cap[empty]  = c.cap;
                live_cnt         = live_cnt + 1'b1;
            end else begin
                // full pool: someone leaves, either the smallest slot or the newcomer
                r.dropped = 1'b1;
                if (c.cap > pool_cap[best]) begin
                    r.dropped_id   = pool_id[best];
                    pool_id[best]  = c.id;
                    pool_cap[best] = c.cap;
                end else begin
                    r.dropped_id = c.id;
                end
            end
        end
        r.free_cnt = live_cnt;
        r.q_cnt    = out_cnt;
        r.q_bytes  = byte_sum;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------------------
    pool_cmd_t   cmd_backlog[$];    // words not yet offered
    pool_res_t   owed_results[$];   // predictions waiting for their result word
    int unsigned n_total = 0;
    int unsigned n_taken = 0;
    int unsigned n_bad   = 0;

    function automatic pool_cmd_t get_cmd(logic [BYTES_W-1:0] req);
        pool_cmd_t c;
        c     = '0;
        c.op  = CMD_GET;
        c.req = req;
        return c;
    endfunction

    function automatic pool_cmd_t recycle_cmd(logic [ID_W-1:0] id, logic [BYTES_W-1:0] cap,
                                              logic [BYTES_W-1:0] used);
        pool_cmd_t c;
        c      = '0;
        c.op   = CMD_RECYCLE;
        c.id   = id;
        c.cap  = cap;
        c.used = used;
        return c;
    endfunction

    // sizes cluster on a coarse grid so best-fit ties and near misses are common
    function automatic logic [BYTES_W-1:0] size_draw();
        case ($urandom_range(0, 9))
            0, 1:    return BYTES_W'($urandom());
            2:       return $urandom_range(0, 1) ? {BYTES_W{1'b1}} : '0;
            default: return BYTES_W'($urandom_range(0, 15) * 64 +
                                     ($urandom_range(0, 2) == 0 ? $urandom_range(0, 63) : 0));
        endcase
    endfunction

    // mode 0 fills the pool, 1 drains it, 2 is balanced
    function automatic pool_cmd_t random_cmd(int unsigned mode);
        pool_cmd_t   c;
        int unsigned recycle_pct;
        recycle_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
        c.op   = ($urandom_range(0, 99) < recycle_pct) ? CMD_RECYCLE : CMD_GET;
        c.req  = size_draw();
        c.id   = ID_W'($urandom_range(0, 65535));
        c.cap  = size_draw();
        c.used = $urandom_range(0, 1) ? BYTES_W'($urandom()) : BYTES_W'($urandom_range(0, 1023));
        c.drain_first = 1'b0;
        return c;
    endfunction

    int unsigned mode;
    pool_cmd_t   rnd;

    // sender state, shared with the end-of-run wait below
    pool_cmd_t   offered = '0;
    logic        word_up = 1'b0;
    logic        s_fire  = 1'b0;   // set at the rising edge, read at the next falling edge
    logic        m_fire  = 1'b0;
    int unsigned src_gap = 0;

    initial begin
        // directed: recycle into an empty pool with nothing out, so both counters wrap low
        cmd_backlog.push_back(recycle_cmd(16'h0000, 24'h000000, 24'hFFFFFF));
        // zero-byte get takes the capacity-0 buffer
        cmd_backlog.push_back(get_cmd(24'h000000));
        // misses on an empty pool, smallest and largest request
        cmd_backlog.push_back(get_cmd(24'h000000));
        cmd_backlog.push_back(get_cmd(24'hFFFFFF));
        // fill every slot; capacities repeat so 0 and 64 tie across several slots
        for (int k = 0; k < POOL_SLOTS; k++)
            cmd_backlog.push_back(recycle_cmd((k == 7) ? 16'hFFFF : ID_W'(16'h8000 | k),
                                              (k == 3) ? 24'hFFFFFF : BYTES_W'((k % 5) * 64),
                                              (k % 2) ? 24'h000000 : 24'hFFFFFF));
        // full pool, newcomer equal to the smallest: newcomer is dropped
        cmd_backlog.push_back(recycle_cmd(16'h5A5A, 24'h000000, 24'h000001));
        // full pool, newcomer larger: lowest-index smallest slot is evicted
        cmd_backlog.push_back(recycle_cmd(16'hA5A5, 24'h000001, 24'h800000));
        // ties on capacity 0 resolve to the lowest index; then the largest buffer
        cmd_backlog.push_back(get_cmd(24'h000000));
        cmd_backlog.push_back(get_cmd(24'hFFFFFF));
        cmd_backlog.push_back(get_cmd(24'h000040));

        mode = 0;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 40 == 0)
                mode = (k == 0) ? 0 : $urandom_range(0, 2);
            rnd = random_cmd(mode);
            // the sender empties the pipe before the random part and once midway
            rnd.drain_first = (k == 0 || k == 800);
            cmd_backlog.push_back(rnd);
        end
        n_total = cmd_backlog.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered and taken, then every result in, then a short tail
        while (cmd_backlog.size() != 0 || word_up)
            @(negedge i_clk);
        while (owed_results.size() != 0)
            @(negedge i_clk);
        repeat (POOL_SLOTS + 8) @(negedge i_clk);

        if (n_bad == 0 && owed_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // idling stops for the tail of the run and for one stretch in every four hundred words
    function automatic bit calm();
        return (n_taken + QUIET_TAIL >= n_total) || ((n_taken / 100) % 4 == 3);
    endfunction

    // ---------------------------------------------------------------------------------------
    // Sender: changes the slave side on falling edges, holds a word until it is taken.
    // ---------------------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_fire)
                word_up = 1'b0;
            if (!word_up) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (cmd_backlog.size() != 0 &&
                             !(cmd_backlog[0].drain_first && owed_results.size() != 0)) begin
                    offered = cmd_backlog.pop_front();
                    word_up = 1'b1;
                    // the gap, if any, follows this word once it is taken
                    if (!calm() && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 8);
                end
            end
            i_s_tvalid <= word_up;
            i_s_tdata  <= {offered.used, offered.cap, offered.id, offered.req};
            i_s_tuser  <= offered.op;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off that backs the block up to its input.
    // ---------------------------------------------------------------------------------------
    int unsigned sink_gap   = 0;
    int unsigned sink_hold  = 0;
    logic        held_once  = 1'b0;
    logic        sink_ready = 1'b0;

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            sink_ready = 1'b0;
        end else if (!held_once && n_taken >= SINK_HOLD_AT) begin
            held_once  = 1'b1;
            sink_hold  = SINK_HOLD - 1;
            sink_ready = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            sink_ready = 1'b0;
        end else if (i_rst_n && !calm() && $urandom_range(0, 5) == 0) begin
            sink_gap   = $urandom_range(1, 8) - 1;
            sink_ready = 1'b0;
        end else begin
            sink_ready = 1'b1;
        end
        i_m_tready <= sink_ready;
    end

    // ---------------------------------------------------------------------------------------
    // Monitor: rising-edge sampling of both handshakes, prediction, checking, watchdog.
    // ---------------------------------------------------------------------------------------
    pool_res_t   seen;
    pool_res_t   want;
    int unsigned still_cycles = 0;

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            n_bad++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            s_fire = i_s_tvalid && o_s_tready;
            m_fire = o_m_tvalid && i_m_tready;
            if (m_fire) begin
                if (owed_results.size() == 0) begin
                    $error("result word with no command outstanding");
                    n_bad++;
                end else begin
                    seen.hit        = o_m_tuser[0];
                    seen.dropped    = o_m_tuser[1];
                    seen.out_id     = o_m_tdata[15:0];
                    seen.alloc      = o_m_tdata[40:16];
                    seen.dropped_id = o_m_tdata[56:41];
                    seen.free_cnt   = o_m_tdata[63:57];
                    seen.q_cnt      = o_m_tdata[79:64];
                    seen.q_bytes    = o_m_tdata[111:80];
                    want = owed_results.pop_front();
                    check_field("hit",          32'(want.hit),        32'(seen.hit));
                    check_field("out_id",       32'(want.out_id),     32'(seen.out_id));
                    check_field("alloc_bytes",  32'(want.alloc),      32'(seen.alloc));
                    check_field("dropped",      32'(want.dropped),    32'(seen.dropped));
                    check_field("dropped_id",   32'(want.dropped_id), 32'(seen.dropped_id));
                    check_field("free_count",   32'(want.free_cnt),   32'(seen.free_cnt));
                    check_field("queued_count", 32'(want.q_cnt),      32'(seen.q_cnt));
                    check_field("queued_bytes", want.q_bytes,         seen.q_bytes);
                end
            end
            if (s_fire) begin
                owed_results.push_back(pool_step(offered));
                n_taken++;
            end
            still_cycles = (s_fire || m_fire) ? 0 : still_cycles + 1;
            if (still_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
